/* rtl/nprs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_pkg: shared constants and types for the nearest point to ray selector
// Widths of the fixed-point distance datapath, register indexes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nprs_pkg;

	// Largest number of points of one object that take part in the search.
	localparam int MAX_POINTS = 65536;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int IDX_W      = $clog2(MAX_POINTS);

	localparam int COORD_W = 16;
	localparam int INDEX_W = 16;
	localparam int DIST_W  = 40;
	localparam int V_W     = COORD_W + 1;      // point minus origin
	localparam int PROD_W  = V_W + COORD_W;    // v * d
	localparam int DOT_W   = PROD_W + 2;       // sum of three products
	localparam int T_W     = DOT_W + COORD_W;  // dot * d
	localparam int FRAC    = 28;               // Q.28 before rounding
	localparam int X_W     = T_W + 1;
	localparam int R_W     = X_W - FRAC;
	localparam int SQ_W    = 2 * R_W;
	localparam int SUM_W   = SQ_W + 2;

	localparam logic signed [X_W-1:0] ROUND_HALF = X_W'(1) <<< (FRAC - 1);
	localparam logic [DIST_W-1:0]     DIST_MAX   = '1;

	localparam logic signed [COORD_W-1:0] DIR_Z_RESET = 16'sd16384;

	// Register indexes, byte address divided by four.
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X    = 3'd3;
	localparam logic [2:0] REG_DIR_Y    = 3'd4;
	localparam logic [2:0] REG_DIR_Z    = 3'd5;

	typedef struct packed {
		logic load_in;
		logic mul_en;
		logic dot_en;
		logic tmul_en;
		logic rnd_en;
		logic sqr_en;
		logic sum_en;
		logic upd_en;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

endpackage

/* rtl/nearest_point_to_ray_select.sv */
`timescale 1ns / 1ps
// The result register loads when the final point leaves its update step.
// One point at a time: in_stall holds the input while the sequencer steps it
// through subtract, multiply, dot, multiply, round, square, sum and update.
// A stalled result holds the final point in its update step until it moves.
// Reset (arst_n low) clears the running minimum and the point count and loads
// the registers with origin (0, 0, 0) and direction (0, 0, 16384).
// ----------------------------------------------------------------------------
// nearest_point_to_ray_select: nearest point to a ray
// Finds the point of a stream closest to a configured ray by squared
// perpendicular distance and reports it on the point marked last.
// ----------------------------------------------------------------------------
module nearest_point_to_ray_select (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [nprs_pkg::COORD_W-1:0] point_x,
	input  logic signed [nprs_pkg::COORD_W-1:0] point_y,
	input  logic signed [nprs_pkg::COORD_W-1:0] point_z,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nprs_pkg::INDEX_W-1:0]        hit_index,
	output logic signed [nprs_pkg::COORD_W-1:0] hit_x,
	output logic signed [nprs_pkg::COORD_W-1:0] hit_y,
	output logic signed [nprs_pkg::COORD_W-1:0] hit_z,
	output logic [nprs_pkg::DIST_W-1:0]         hit_distance_sq
);

	logic signed [nprs_pkg::COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic signed [nprs_pkg::COORD_W-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic signed [nprs_pkg::COORD_W-1:0] rd_val;
	logic [2:0]                          reg_idx;
	logic                                wr_en;
	nprs_pkg::dp_cmd_t                   cmd;
	nprs_pkg::dp_stat_t                  stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			dir_x_q    <= '0;
			dir_y_q    <= '0;
			dir_z_q    <= nprs_pkg::DIR_Z_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				nprs_pkg::REG_ORIGIN_X: origin_x_q <= $signed(pwdata[15:0]);
				nprs_pkg::REG_ORIGIN_Y: origin_y_q <= $signed(pwdata[15:0]);
				nprs_pkg::REG_ORIGIN_Z: origin_z_q <= $signed(pwdata[15:0]);
				nprs_pkg::REG_DIR_X:    dir_x_q    <= $signed(pwdata[15:0]);
				nprs_pkg::REG_DIR_Y:    dir_y_q    <= $signed(pwdata[15:0]);
				nprs_pkg::REG_DIR_Z:    dir_z_q    <= $signed(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			nprs_pkg::REG_ORIGIN_X: rd_val = origin_x_q;
			nprs_pkg::REG_ORIGIN_Y: rd_val = origin_y_q;
			nprs_pkg::REG_ORIGIN_Z: rd_val = origin_z_q;
			nprs_pkg::REG_DIR_X:    rd_val = dir_x_q;
			nprs_pkg::REG_DIR_Y:    rd_val = dir_y_q;
			nprs_pkg::REG_DIR_Z:    rd_val = dir_z_q;
			default:                rd_val = '0;
		endcase
	end

	assign prdata = 32'(rd_val);

	nprs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	nprs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.origin_x        (origin_x_q),
		.origin_y        (origin_y_q),
		.origin_z        (origin_z_q),
		.dir_x           (dir_x_q),
		.dir_y           (dir_y_q),
		.dir_z           (dir_z_q),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.last_point      (last_point),
		.hit_index       (hit_index),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.hit_z           (hit_z),
		.hit_distance_sq (hit_distance_sq)
	);

endmodule

/* rtl/nprs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_ctrl: sequencer for the nearest point search
// Steps one point at a time through the distance datapath and owns the
// input stall and the output valid of the result register.
// ----------------------------------------------------------------------------
module nprs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  nprs_pkg::dp_stat_t  stat,
	output nprs_pkg::dp_cmd_t   cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MUL  = 8'b0000_0010,
		S_DOT  = 8'b0000_0100,
		S_TMUL = 8'b0000_1000,
		S_RND  = 8'b0001_0000,
		S_SQR  = 8'b0010_0000,
		S_SUM  = 8'b0100_0000,
		S_UPD  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   upd_go;

	assign out_free  = !out_valid_q || !out_stall;
	// A final point waits in the update step until the result register is free.
	assign upd_go    = (state_q == S_UPD) && (!stat.last || out_free);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.load_in = (state_q == S_IDLE) && in_valid;
		cmd.mul_en  = (state_q == S_MUL);
		cmd.dot_en  = (state_q == S_DOT);
		cmd.tmul_en = (state_q == S_TMUL);
		cmd.rnd_en  = (state_q == S_RND);
		cmd.sqr_en  = (state_q == S_SQR);
		cmd.sum_en  = (state_q == S_SUM);
		cmd.upd_en  = upd_go;
		cmd.emit    = upd_go && stat.last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_MUL;
			S_MUL:  state_d = S_DOT;
			S_DOT:  state_d = S_TMUL;
			S_TMUL: state_d = S_RND;
			S_RND:  state_d = S_SQR;
			S_SQR:  state_d = S_SUM;
			S_SUM:  state_d = S_UPD;
			S_UPD:  if (upd_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MUL))
		else $error("accepted point did not start the distance sequence");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_UPD))
		else $error("result appeared outside the update step");

	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && stat.last && out_valid_q && out_stall) |=>
		(state_q == S_UPD))
		else $error("final point left the update step while the result was stalled");

endmodule

/* rtl/nprs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_dp: distance datapath and running minimum
// Squared perpendicular distance of a point to the ray in fixed point,
// the best point of the current object and the result register.
// ----------------------------------------------------------------------------
module nprs_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  nprs_pkg::dp_cmd_t                       cmd,
	output nprs_pkg::dp_stat_t                      stat,
	input  logic signed [nprs_pkg::COORD_W-1:0]     origin_x,
	input  logic signed [nprs_pkg::COORD_W-1:0]     origin_y,
	input  logic signed [nprs_pkg::COORD_W-1:0]     origin_z,
	input  logic signed [nprs_pkg::COORD_W-1:0]     dir_x,
	input  logic signed [nprs_pkg::COORD_W-1:0]     dir_y,
	input  logic signed [nprs_pkg::COORD_W-1:0]     dir_z,
	input  logic signed [nprs_pkg::COORD_W-1:0]     point_x,
	input  logic signed [nprs_pkg::COORD_W-1:0]     point_y,
	input  logic signed [nprs_pkg::COORD_W-1:0]     point_z,
	input  logic                                    last_point,
	output logic [nprs_pkg::INDEX_W-1:0]            hit_index,
	output logic signed [nprs_pkg::COORD_W-1:0]     hit_x,
	output logic signed [nprs_pkg::COORD_W-1:0]     hit_y,
	output logic signed [nprs_pkg::COORD_W-1:0]     hit_z,
	output logic [nprs_pkg::DIST_W-1:0]             hit_distance_sq
);

	localparam int COORD_W = nprs_pkg::COORD_W;
	localparam int V_W     = nprs_pkg::V_W;
	localparam int PROD_W  = nprs_pkg::PROD_W;
	localparam int DOT_W   = nprs_pkg::DOT_W;
	localparam int T_W     = nprs_pkg::T_W;
	localparam int X_W     = nprs_pkg::X_W;
	localparam int R_W     = nprs_pkg::R_W;
	localparam int SQ_W    = nprs_pkg::SQ_W;
	localparam int SUM_W   = nprs_pkg::SUM_W;
	localparam int DIST_W  = nprs_pkg::DIST_W;
	localparam int CNT_W   = nprs_pkg::CNT_W;
	localparam int IDX_W   = nprs_pkg::IDX_W;
	localparam int INDEX_W = nprs_pkg::INDEX_W;
	localparam int FRAC    = nprs_pkg::FRAC;

	// Point held for the whole sequence of one item.
	logic signed [COORD_W-1:0] px_s1, py_s1, pz_s1;
	logic                      last_s1;
	logic signed [V_W-1:0]     vx_s1, vy_s1, vz_s1;
	logic signed [PROD_W-1:0]  prx_s2, pry_s2, prz_s2;
	logic signed [DOT_W-1:0]   dot_s3;
	logic signed [T_W-1:0]     tx_s4, ty_s4, tz_s4;
	logic signed [R_W-1:0]     rx_s5, ry_s5, rz_s5;
	logic [SQ_W-1:0]           sqx_s6, sqy_s6, sqz_s6;
	logic [DIST_W-1:0]         dist_s7;

	logic signed [X_W-1:0]     xx, xy, xz;
	logic [SUM_W-1:0]          sum;

	logic [DIST_W-1:0]         best_dist_q, best_dist_d;
	logic [IDX_W-1:0]          best_idx_q, best_idx_d;
	logic signed [COORD_W-1:0] best_x_q, best_y_q, best_z_q;
	logic signed [COORD_W-1:0] best_x_d, best_y_d, best_z_d;
	logic [CNT_W-1:0]          count_q;
	logic                      counted;
	logic                      take;
	logic [IDX_W+INDEX_W-1:0]  idx_ext;

	assign stat.last = last_s1;

	// Rounding half up: add one half, then keep the integer part.
	assign xx = (X_W'(vx_s1) <<< FRAC) - X_W'(tx_s4) + nprs_pkg::ROUND_HALF;
	assign xy = (X_W'(vy_s1) <<< FRAC) - X_W'(ty_s4) + nprs_pkg::ROUND_HALF;
	assign xz = (X_W'(vz_s1) <<< FRAC) - X_W'(tz_s4) + nprs_pkg::ROUND_HALF;

	assign sum = SUM_W'(sqx_s6) + SUM_W'(sqy_s6) + SUM_W'(sqz_s6);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_s1   <= point_x;
			py_s1   <= point_y;
			pz_s1   <= point_z;
			last_s1 <= last_point;
			vx_s1   <= V_W'(point_x) - V_W'(origin_x);
			vy_s1   <= V_W'(point_y) - V_W'(origin_y);
			vz_s1   <= V_W'(point_z) - V_W'(origin_z);
		end
		if (cmd.mul_en) begin
			prx_s2 <= vx_s1 * dir_x;
			pry_s2 <= vy_s1 * dir_y;
			prz_s2 <= vz_s1 * dir_z;
		end
		if (cmd.dot_en) begin
			dot_s3 <= DOT_W'(prx_s2) + DOT_W'(pry_s2) + DOT_W'(prz_s2);
		end
		if (cmd.tmul_en) begin
			tx_s4 <= dot_s3 * dir_x;
			ty_s4 <= dot_s3 * dir_y;
			tz_s4 <= dot_s3 * dir_z;
		end
		if (cmd.rnd_en) begin
			rx_s5 <= $signed(xx[X_W-1:FRAC]);
			ry_s5 <= $signed(xy[X_W-1:FRAC]);
			rz_s5 <= $signed(xz[X_W-1:FRAC]);
		end
		if (cmd.sqr_en) begin
			sqx_s6 <= $unsigned(SQ_W'(rx_s5) * SQ_W'(rx_s5));
			sqy_s6 <= $unsigned(SQ_W'(ry_s5) * SQ_W'(ry_s5));
			sqz_s6 <= $unsigned(SQ_W'(rz_s5) * SQ_W'(rz_s5));
		end
		if (cmd.sum_en) begin
			dist_s7 <= (|sum[SUM_W-1:DIST_W]) ? nprs_pkg::DIST_MAX : sum[DIST_W-1:0];
		end
	end

	// Points beyond the limit are not compared; the first point always wins.
	assign counted = (count_q < CNT_W'(nprs_pkg::MAX_POINTS));
	assign take    = counted && ((count_q == '0) || (dist_s7 < best_dist_q));

	always_comb begin
		best_dist_d = best_dist_q;
		best_idx_d  = best_idx_q;
		best_x_d    = best_x_q;
		best_y_d    = best_y_q;
		best_z_d    = best_z_q;
		if (take) begin
			best_dist_d = dist_s7;
			best_idx_d  = count_q[IDX_W-1:0];
			best_x_d    = px_s1;
			best_y_d    = py_s1;
			best_z_d    = pz_s1;
		end
	end

	assign idx_ext = {{INDEX_W{1'b0}}, best_idx_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= nprs_pkg::DIST_MAX;
			best_idx_q  <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_z_q    <= '0;
			count_q     <= '0;
		end else if (cmd.upd_en) begin
			if (cmd.emit) begin
				best_dist_q <= nprs_pkg::DIST_MAX;
				best_idx_q  <= '0;
				best_x_q    <= '0;
				best_y_q    <= '0;
				best_z_q    <= '0;
				count_q     <= '0;
			end else begin
				best_dist_q <= best_dist_d;
				best_idx_q  <= best_idx_d;
				best_x_q    <= best_x_d;
				best_y_q    <= best_y_d;
				best_z_q    <= best_z_d;
				if (counted) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit_index       <= idx_ext[INDEX_W-1:0];
			hit_x           <= best_x_d;
			hit_y           <= best_y_d;
			hit_z           <= best_z_d;
			hit_distance_sq <= best_dist_d;
		end
	end

	a_best_index_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (CNT_W'(best_idx_q) < count_q))
		else $error("best index refers to a point not yet seen");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (count_q == '0 && best_dist_q == nprs_pkg::DIST_MAX))
		else $error("running state not cleared after the result");

endmodule
